>>> rtl/core/dscat_pkg.sv
`default_nettype none

package dscat_pkg;

    // Cohesion radius: near the front, small moves are snapped to zero.
    localparam int unsigned COHESION = 4;
    localparam int unsigned COH_SQ   = COHESION * COHESION;

    // Position hash constants.
    localparam logic [31:0] MIX_XOR  = 32'd61;
    localparam logic [31:0] MIX_MULT = 32'h27d4eb2d;

    // d/10 as (d * 0xCCCD) >> 19, exact for every 16-bit d.
    localparam logic [15:0] DIV10_RECIP = 16'hCCCD;
    localparam int unsigned DIV10_SHIFT = 19;

    localparam logic [9:0] ALPHA_BASE = 10'h200;
    localparam logic [7:0] ALPHA_MAX  = 8'd255;

    // Queue between the classifying front and the writing back end.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_STEP   = 2'd2
    } cfg_reg_t;

    // One surviving block: in-bounds target, alpha and source pixels.
    typedef struct packed {
        logic [12:0] xd;
        logic [12:0] yd;
        logic [7:0]  alpha;
        logic [31:0] px3;
        logic [31:0] px2;
        logic [31:0] px1;
        logic [31:0] px0;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

>>> rtl/core/dust_scatter_pixel_block_unit.sv
// Channel   Dir  Width  Contents
// s_        in   168    one 2x2 pixel block word
// m_        out  152    one scaled, relocated block word
// cfg_      in   15     register writes, index 0..2
//
// A block word is accepted every cycle while the queue has room; a surviving
// block passes the six front stages, the queue and the back-end output
// register before it appears on m_tdata. Reset is synchronous and clears
// the valid bits and the queue, and returns the registers to reset values.
// A stalled m_ side fills the four-entry queue before s_tready drops.
`default_nettype none

module dust_scatter_pixel_block_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // From bit 0: block_x[12], block_y[12], region_top[12], pixel_top_left[32],
    // pixel_top_right[32], pixel_bottom_left[32], pixel_bottom_right[32], 4 zero bits.
    input  wire logic [167:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // From bit 0: dest_index[24], out_first[32], out_second[32], out_third[32],
    // out_fourth[32].
    output logic [151:0]      m_tdata,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [14:0]  cfg_wdata
);
    import dscat_pkg::*;

    logic [12:0] width_reg, width_next;
    logic [12:0] height_reg, height_next;
    logic [14:0] step_reg, step_next;

    logic        q_push, q_pop;
    q_entry_t    q_wdata, q_rdata;
    q_status_t   q_stat;

    logic [23:0] dest_index;
    logic [31:0] out_first, out_second, out_third, out_fourth;

    // Configuration writes; an index past the last register is ignored.
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        step_next   = step_reg;
        if (cfg_we) begin
            case (cfg_addr)
                CFG_WIDTH:  width_next  = cfg_wdata[12:0];
                CFG_HEIGHT: height_next = cfg_wdata[12:0];
                CFG_STEP:   step_next   = cfg_wdata;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 13'd1024;
            height_reg <= 13'd1024;
            step_reg   <= 15'd0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            step_reg   <= step_next;
        end
    end

    // The front hashes, computes motion and alpha, and drops blocks that fade
    // out or leave the image; only survivors enter the queue.
    dscat_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .in_valid           (s_tvalid),
        .in_ready           (s_tready),
        .block_x            (s_tdata[11:0]),
        .block_y            (s_tdata[23:12]),
        .region_top         (s_tdata[35:24]),
        .pixel_top_left     (s_tdata[67:36]),
        .pixel_top_right    (s_tdata[99:68]),
        .pixel_bottom_left  (s_tdata[131:100]),
        .pixel_bottom_right (s_tdata[163:132]),
        .image_width        (width_reg),
        .image_height       (height_reg),
        .frame_step         (step_reg),
        .q_stat             (q_stat),
        .q_push             (q_push),
        .q_data             (q_wdata)
    );

    dscat_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .status  (q_stat)
    );

    // The back end forms the transposed address and scales the pixels into
    // the output register.
    dscat_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_data       (q_rdata),
        .q_stat       (q_stat),
        .q_pop        (q_pop),
        .image_height (height_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .dest_index   (dest_index),
        .out_first    (out_first),
        .out_second   (out_second),
        .out_third    (out_third),
        .out_fourth   (out_fourth)
    );

    assign m_tdata = {out_fourth, out_third, out_second, out_first, dest_index};

    // The front never writes into a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full)
        else $error("queue written while full");

    // The back end never reads an empty queue.
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("queue read while empty");

    // A result word only appears after the queue held an entry.
    a_out_from_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!q_stat.empty))
        else $error("output word without a queued block");

endmodule

`default_nettype wire

>>> rtl/core/dscat_front.sv
`default_nettype none

module dscat_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [11:0]          block_x,
    input  wire logic [11:0]          block_y,
    input  wire logic [11:0]          region_top,
    input  wire logic [31:0]          pixel_top_left,
    input  wire logic [31:0]          pixel_top_right,
    input  wire logic [31:0]          pixel_bottom_left,
    input  wire logic [31:0]          pixel_bottom_right,
    input  wire logic [12:0]          image_width,
    input  wire logic [12:0]          image_height,
    input  wire logic [14:0]          frame_step,
    input  wire dscat_pkg::q_status_t q_stat,
    output logic                      q_push,
    output dscat_pkg::q_entry_t       q_data
);
    import dscat_pkg::*;

    typedef struct packed {
        logic [11:0]  bx;
        logic [11:0]  by;
        logic [127:0] px;
    } pay_t;

    logic        adv;
    logic [5:0]  vld_reg, vld_next;
    pay_t        pay_reg [6];
    pay_t        pay_in;

    // Stage 1: clamped row distance and linear position.
    logic signed [17:0] d_full;
    logic [15:0] d_next, d_reg;
    logic [24:0] pos_next, pos_reg;
    // Stage 2: first half of the hash, square and reciprocal products.
    logic [31:0] m1, m2;
    logic [31:0] mix_next, mix_reg;
    logic [31:0] dsq_next, dsq_reg;
    logic [31:0] dq_next, dq_reg;
    // Stage 3: hash multiply, distance, vertical pull.
    logic [12:0] quot;
    logic [31:0] hm_next, hm_reg;
    logic [11:0] dist_next, dist_reg;
    logic [15:0] sv_next, sv3_reg, sv4_reg;
    logic        near_next, near3_reg, near4_reg, near5_reg;
    // Stage 4: velocity products and raw alpha.
    logic [31:0] hash;
    logic signed [20:0] dist_s, vx_s, vy_s;
    logic signed [20:0] prx_next, prx_reg, pry_next, pry_reg;
    logic signed [15:0] alpha_raw_next, alpha_raw_reg;
    // Stage 5: displacements and limited alpha.
    logic signed [17:0] dx_next, dx_reg;
    logic signed [14:0] dy_next, dy_reg;
    logic [7:0]  alpha_next, alpha5_reg, alpha6_reg;
    logic        aneg_next, aneg5_reg, aneg6_reg;
    // Stage 6: cohesion snap and raw targets.
    logic signed [10:0] dxe, dye;
    logic [10:0] sq;
    logic        zero_next, zero_reg;
    logic signed [17:0] xd_next, xd_reg, xd_f, wlim;
    logic signed [14:0] yd_next, yd_reg, yd_f, hlim;
    logic        in_x, in_y, keep;

    assign pay_in = '{bx: block_x, by: block_y,
                      px: {pixel_bottom_right, pixel_bottom_left,
                           pixel_top_right, pixel_top_left}};

    // Final classification from the last stage.
    always_comb begin
        xd_f = zero_reg ? $signed({6'b0, pay_reg[5].bx}) : xd_reg;
        yd_f = zero_reg ? $signed({3'b0, pay_reg[5].by}) : yd_reg;
        wlim = $signed({5'b0, image_width}) - 18'sd1;
        hlim = $signed({2'b0, image_height}) - 15'sd1;
        in_x = !xd_f[17] && (xd_f < wlim);
        in_y = !yd_f[14] && (yd_f < hlim);
        keep = !aneg6_reg && in_x && in_y;
    end

    // The whole front advances together; it holds only when a kept block
    // is waiting on a full queue.
    assign adv      = !(vld_reg[5] && keep) || !q_stat.full;
    assign in_ready = adv;
    assign q_push   = vld_reg[5] && keep && adv;

    assign q_data = '{xd: xd_f[12:0], yd: yd_f[12:0], alpha: alpha6_reg,
                      px3: pay_reg[5].px[127:96], px2: pay_reg[5].px[95:64],
                      px1: pay_reg[5].px[63:32], px0: pay_reg[5].px[31:0]};

    always_comb begin
        vld_next = adv ? {vld_reg[4:0], in_valid} : vld_reg;

        d_full   = $signed({3'b0, frame_step}) - $signed({6'b0, block_y})
                 + $signed({6'b0, region_top});
        d_next   = d_full[17] ? 16'd0 : d_full[15:0];
        pos_next = 25'(block_y) * 25'(image_width) + 25'(block_x);

        m1       = {7'b0, pos_reg} ^ MIX_XOR ^ ({7'b0, pos_reg} >> 16);
        m2       = (m1 << 3) + m1;
        mix_next = m2 ^ (m2 >> 4);
        dsq_next = 32'(d_reg) * 32'(d_reg);
        dq_next  = 32'(d_reg) * 32'(DIV10_RECIP);

        hm_next   = mix_reg * MIX_MULT;
        quot      = dq_reg[31:DIV10_SHIFT];
        dist_next = quot[11:0] + 12'(COHESION);
        near_next = (quot == 13'd0);
        sv_next   = dsq_reg[30:15];

        hash   = hm_reg ^ (hm_reg >> 15);
        dist_s = 21'($signed({1'b0, dist_reg}));
        vx_s   = 21'($signed(hash[7:0]));
        vy_s   = 21'($signed(hash[15:8]));
        prx_next = dist_s * vx_s;
        pry_next = dist_s * vy_s;
        alpha_raw_next = 16'(ALPHA_BASE) + 16'(hash[24:16]) - {2'b0, dist_reg, 2'b0};

        dx_next    = 18'(prx_reg >>> 8) - $signed({2'b0, sv4_reg});
        dy_next    = 15'(pry_reg >>> 8);
        aneg_next  = alpha_raw_reg[15];
        alpha_next = (alpha_raw_reg > 16'sd255) ? ALPHA_MAX : alpha_raw_reg[7:0];

        // Near the front the pull is zero and both moves are tiny, so the
        // low bits carry their whole value there.
        dxe       = 11'($signed(dx_reg[4:0]));
        dye       = 11'($signed(dy_reg[4:0]));
        sq        = 11'(dxe * dxe) + 11'(dye * dye);
        zero_next = near5_reg && (sq < 11'(COH_SQ));
        xd_next   = $signed({6'b0, pay_reg[4].bx}) + dx_reg;
        yd_next   = $signed({3'b0, pay_reg[4].by}) + dy_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pay_reg[0] <= pay_in;
            for (int i = 1; i < 6; i++) begin
                pay_reg[i] <= pay_reg[i-1];
            end
            d_reg         <= d_next;
            pos_reg       <= pos_next;
            mix_reg       <= mix_next;
            dsq_reg       <= dsq_next;
            dq_reg        <= dq_next;
            hm_reg        <= hm_next;
            dist_reg      <= dist_next;
            near3_reg     <= near_next;
            sv3_reg       <= sv_next;
            prx_reg       <= prx_next;
            pry_reg       <= pry_next;
            alpha_raw_reg <= alpha_raw_next;
            near4_reg     <= near3_reg;
            sv4_reg       <= sv3_reg;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            aneg5_reg     <= aneg_next;
            alpha5_reg    <= alpha_next;
            near5_reg     <= near4_reg;
            zero_reg      <= zero_next;
            xd_reg        <= xd_next;
            yd_reg        <= yd_next;
            aneg6_reg     <= aneg5_reg;
            alpha6_reg    <= alpha5_reg;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/dscat_fifo.sv
`default_nettype none

module dscat_fifo (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire dscat_pkg::q_entry_t  wdata,
    input  wire logic                 pop,
    output dscat_pkg::q_entry_t       rdata,
    output dscat_pkg::q_status_t      status
);
    import dscat_pkg::*;

    q_entry_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    assign status.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign rdata        = mem[rptr_reg];

    always_comb begin
        wptr_next = push ? QPTR_W'(wptr_reg + 1'b1) : wptr_reg;
        rptr_next = pop  ? QPTR_W'(rptr_reg + 1'b1) : rptr_reg;
        cnt_next  = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/dscat_back.sv
`default_nettype none

module dscat_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire dscat_pkg::q_entry_t  q_data,
    input  wire dscat_pkg::q_status_t q_stat,
    output logic                      q_pop,
    input  wire logic [12:0]          image_height,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [23:0]               dest_index,
    output logic [31:0]               out_first,
    output logic [31:0]               out_second,
    output logic [31:0]               out_third,
    output logic [31:0]               out_fourth
);
    import dscat_pkg::*;

    // Each byte becomes (c * alpha) >> 8.
    function automatic logic [31:0] fade_px(input logic [31:0] px, input logic [7:0] a);
        logic [15:0] prod;
        logic [31:0] r;
        r = '0;
        for (int k = 0; k < 4; k++) begin
            prod = 16'(px[8*k +: 8]) * 16'(a);
            r[8*k +: 8] = prod[15:8];
        end
        return r;
    endfunction

    logic        vld_reg, vld_next, load;
    logic [23:0] idx_reg, idx_next;
    logic [31:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic [31:0] p0_next, p1_next, p2_next, p3_next;
    logic [25:0] col;

    assign load  = !q_stat.empty && (!vld_reg || out_ready);
    assign q_pop = load;

    always_comb begin
        col      = 26'(q_data.xd) * 26'(image_height);
        idx_next = 24'(q_data.yd) + col[23:0];
        p0_next  = fade_px(q_data.px0, q_data.alpha);
        p1_next  = fade_px(q_data.px1, q_data.alpha);
        p2_next  = fade_px(q_data.px2, q_data.alpha);
        p3_next  = fade_px(q_data.px3, q_data.alpha);
        vld_next = load ? 1'b1 : (out_ready ? 1'b0 : vld_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            idx_reg <= idx_next;
            p0_reg  <= p0_next;
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            p3_reg  <= p3_next;
        end
    end

    assign out_valid  = vld_reg;
    assign dest_index = idx_reg;
    assign out_first  = p0_reg;
    assign out_second = p1_reg;
    assign out_third  = p2_reg;
    assign out_fourth = p3_reg;

endmodule

`default_nettype wire

>>> tb/sv/dust_scatter_pixel_block_unit_tb.sv
module dust_scatter_pixel_block_unit_tb;
    import dscat_pkg::*;

    // Register index with no register behind it; writes to it must change nothing.
    localparam logic [1:0] CFG_SPARE = 2'd3;

    // Blocks that moved less than this radius near the front are snapped back.
    localparam longint SNAP_RADIUS = 4;

    // Cycles allowed after the last expected word before the block counts as idle.
    // This covers the front pipeline, the four-entry queue and some margin.
    localparam int DRAIN_CYCLES = 24;

    // Length of the long receiver hold that fills the queue and stalls the input.
    localparam int HOLD_CYCLES = 300;

    // Hard limit on the run, far above the slowest correct run.
    localparam int LIMIT_CYCLES = 400000;

    // One input word, declared from the top bits down so that block_x lands in bit 0.
    typedef struct packed {
        logic [31:0] pixel_bottom_right;
        logic [31:0] pixel_bottom_left;
        logic [31:0] pixel_top_right;
        logic [31:0] pixel_top_left;
        logic [11:0] region_top;
        logic [11:0] block_y;
        logic [11:0] block_x;
    } pixel_block_t;

    // One result word, declared from the top bits down so that dest_index lands in bit 0.
    typedef struct packed {
        logic [31:0] out_fourth;
        logic [31:0] out_third;
        logic [31:0] out_second;
        logic [31:0] out_first;
        logic [23:0] dest_index;
    } scatter_word_t;

    typedef enum {ROW_WRITE, ROW_BLOCK} row_kind_t;
    typedef enum {CHK_PREDICT, CHK_DROP, CHK_GIVEN} check_kind_t;

    // One line of the directed table: either a register write or a block with
    // the way its outcome is known.
    typedef struct {
        row_kind_t     kind;
        logic [1:0]    reg_idx;
        logic [14:0]   reg_val;
        pixel_block_t  blk;
        check_kind_t   chk;
        scatter_word_t given;
    } dir_row_t;

    // All inputs start at known values; reset is held low from time zero.
    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    // From bit 0: block_x[12], block_y[12], region_top[12], pixel_top_left[32],
    // pixel_top_right[32], pixel_bottom_left[32], pixel_bottom_right[32], 4 zero bits.
    logic [167:0] s_tdata   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    // From bit 0: dest_index[24], out_first[32], out_second[32], out_third[32],
    // out_fourth[32].
    logic [151:0] m_tdata;
    logic         cfg_we    = 1'b0;
    logic [1:0]   cfg_addr  = '0;
    logic [14:0]  cfg_wdata = '0;

    // Register copies kept by the predictor, starting at their reset values.
    logic [12:0]  img_width    = 13'd1024;
    logic [12:0]  img_height   = 13'd1024;
    logic [14:0]  frame_step_r = 15'd0;

    // Words the block still owes, oldest first.
    scatter_word_t pending_words[$];
    dir_row_t      dir_rows[$];

    int n_err      = 0;
    int n_blocks   = 0;
    int n_words    = 0;
    int n_dropped  = 0;
    int n_settings = 0;

    // Idle percentages for each side, and the request for the long receiver hold.
    int tx_idle_pct = 20;
    int rx_idle_pct = 20;
    bit hold_req    = 1'b0;

    scatter_word_t got_word;
    scatter_word_t want_word;

    dust_scatter_pixel_block_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Each byte of a pixel is faded as (c * alpha) >> 8.
    function automatic logic [31:0] fade_pixel(input logic [31:0] px, input logic [7:0] a);
        logic [31:0] r;
        logic [15:0] prod;
        r = '0;
        for (int k = 0; k < 4; k++) begin
            prod = px[8*k +: 8] * a;
            r[8*k +: 8] = prod[15:8];
        end
        return r;
    endfunction

    // Works out the word that one block produces under the current registers.
    // The return value is zero when the block is dropped.
    function automatic bit predict_scatter(input pixel_block_t b, output scatter_word_t w);
        longint bx, by, top, fs, wl, hl;
        longint d, sv, spread, vx, vy, dx, dy, lifetime, alpha, xd, yd;
        logic [31:0] h;
        logic [63:0] idx;
        logic [7:0]  a8;
        w   = '0;
        bx  = b.block_x;
        by  = b.block_y;
        top = b.region_top;
        fs  = frame_step_r;
        wl  = img_width;
        hl  = img_height;

        // Distance below the region top, pushed along by the frame step.
        d = fs - by + top;
        if (d < 0) begin
            d = 0;
        end
        sv     = -((d * d) >>> 15);
        spread = d / 10 + SNAP_RADIUS;

        // Integer hash of the linear position, wrapping at 32 bits.
        h = b.block_y * img_width + b.block_x;
        h = (h ^ 32'd61) ^ (h >> 16);
        h = h * 32'd9;
        h = h ^ (h >> 4);
        h = h * 32'h27d4eb2d;
        h = h ^ (h >> 15);

        // Velocity bytes are signed; the arithmetic shift gives floor division.
        vx = $signed(h[7:0]);
        vy = $signed(h[15:8]);
        dx = ((spread * vx) >>> 8) + sv;
        dy = (spread * vy) >>> 8;
        if (spread <= SNAP_RADIUS && dx * dx + dy * dy < SNAP_RADIUS * SNAP_RADIUS) begin
            dx = 0;
            dy = 0;
        end

        lifetime = h[24:16];
        alpha    = 512 + lifetime - 4 * spread;
        if (alpha > 255) begin
            alpha = 255;
        end else if (alpha < 0) begin
            return 1'b0;
        end

        xd = bx + dx;
        yd = by + dy;
        if (xd < 0 || xd >= wl - 1 || yd < 0 || yd >= hl - 1) begin
            return 1'b0;
        end

        idx          = yd + xd * hl;
        a8           = 8'(alpha);
        w.dest_index = idx[23:0];
        w.out_first  = fade_pixel(b.pixel_top_left, a8);
        w.out_second = fade_pixel(b.pixel_top_right, a8);
        w.out_third  = fade_pixel(b.pixel_bottom_left, a8);
        w.out_fourth = fade_pixel(b.pixel_bottom_right, a8);
        return 1'b1;
    endfunction

    // Mostly random pixels, with all-zero and all-one pixels mixed in.
    function automatic logic [31:0] rand_pixel();
        case ($urandom_range(0, 15))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    // Builds a random block. Most blocks sit inside the image with a region top
    // chosen so that the dispersal distance mostly lands where alpha can stay positive;
    // the rest are raw noise across the whole field range.
    function automatic pixel_block_t make_block();
        pixel_block_t b;
        int xmax, ymax, dwant, topv;
        b.pixel_top_left     = rand_pixel();
        b.pixel_top_right    = rand_pixel();
        b.pixel_bottom_left  = rand_pixel();
        b.pixel_bottom_right = rand_pixel();
        if ($urandom_range(0, 9) == 0) begin
            b.block_x    = 12'($urandom);
            b.block_y    = 12'($urandom);
            b.region_top = 12'($urandom);
        end else begin
            xmax = (img_width > 13'd4096) ? 4095 : ((img_width == 0) ? 0 : img_width - 1);
            ymax = (img_height > 13'd4096) ? 4095 : ((img_height == 0) ? 0 : img_height - 1);
            b.block_x = 12'($urandom_range(0, xmax));
            b.block_y = 12'($urandom_range(0, ymax));
            // A quarter of the blocks stay near the front, where snapping applies.
            if ($urandom_range(0, 3) == 0) begin
                dwant = $urandom_range(0, 12);
            end else begin
                dwant = $urandom_range(0, 2600);
            end
            topv = int'(b.block_y) + dwant - int'(frame_step_r);
            if (topv < 0) begin
                topv = 0;
            end else if (topv > 4095) begin
                topv = 4095;
            end
            b.region_top = 12'(topv);
        end
        return b;
    endfunction

    function automatic void add_write(input logic [1:0] idx, input logic [14:0] val);
        dir_row_t r;
        r.kind    = ROW_WRITE;
        r.reg_idx = idx;
        r.reg_val = val;
        r.blk     = '0;
        r.chk     = CHK_DROP;
        r.given   = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_block(input logic [11:0] bx, input logic [11:0] by,
                                      input logic [11:0] top, input logic [31:0] p0,
                                      input logic [31:0] p1, input logic [31:0] p2,
                                      input logic [31:0] p3, input check_kind_t chk,
                                      input scatter_word_t given);
        dir_row_t r;
        r.kind    = ROW_BLOCK;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.blk     = {p3, p2, p1, p0, top, by, bx};
        r.chk     = chk;
        r.given   = given;
        dir_rows.push_back(r);
    endfunction

    task automatic report_field(input string name, input logic [31:0] want_v,
                                input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
            n_err++;
        end
    endtask

    // Offers one block and waits for the handshake. At that edge the outcome is
    // recorded: the predicted word, the word typed into the table, or nothing.
    task automatic send_block(input pixel_block_t b, input check_kind_t chk,
                              input scatter_word_t given);
        scatter_word_t w;
        s_tdata  <= {4'b0000, b};
        s_tvalid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        n_blocks++;
        case (chk)
            CHK_PREDICT: begin
                if (predict_scatter(b, w)) begin
                    pending_words.push_back(w);
                end else begin
                    n_dropped++;
                end
            end
            CHK_GIVEN: begin
                pending_words.push_back(given);
            end
            default: begin
                n_dropped++;
            end
        endcase
    endtask

    // A random sender gap, taken at the current idle rate.
    task automatic maybe_pause();
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    // Stops offering and waits until every owed word has come, then lets the
    // pipeline run dry, since dropped blocks leave no word to wait for.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register writes happen only with the block idle. The predictor copy
    // follows the write, keeping only as many bits as the register holds.
    task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_WIDTH: begin
                img_width = val[12:0];
            end
            CFG_HEIGHT: begin
                img_height = val[12:0];
            end
            CFG_STEP: begin
                frame_step_r = val;
            end
            default: begin
            end
        endcase
        @(posedge aclk);
    endtask

    // Every word the block hands over is compared with the oldest owed word.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_word = m_tdata;
            if (pending_words.size() == 0) begin
                $display("%0t: word with none expected, actual %h", $time, got_word);
                n_err++;
            end else begin
                want_word = pending_words.pop_front();
                n_words++;
                report_field("dest_index", want_word.dest_index, got_word.dest_index);
                report_field("out_first", want_word.out_first, got_word.out_first);
                report_field("out_second", want_word.out_second, got_word.out_second);
                report_field("out_third", want_word.out_third, got_word.out_third);
                report_field("out_fourth", want_word.out_fourth, got_word.out_fourth);
            end
        end
    end

    // Receiver side. It stalls in random bursts, and on request holds off for a
    // long stretch so that the queue fills and the block stops taking words.
    initial begin : sink
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                gap = $urandom_range(1, 9);
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int n_items;
        int pcts[3];
        bit burst;
        logic [14:0] wv, hv, sv;

        pcts = '{0, 12, 35};
        burst = 1'b0;

        // Directed table. With reset registers (1024 x 1024, step 0) and a block
        // at or above the region top, the distance is zero: the move snaps to
        // zero, alpha saturates at 255 and every byte c becomes (c * 255) >> 8.
        // Those and two later rows carry typed words; CHK_PREDICT rows use the predictor.
        add_block(12'd0, 12'd0, 12'd0, '1, '1, '1, '1, CHK_GIVEN,
                  {32'hFEFEFEFE, 32'hFEFEFEFE, 32'hFEFEFEFE, 32'hFEFEFEFE, 24'h000000});
        // Last position that still fits: index 1022 + 1022 * 1024.
        add_block(12'd1022, 12'd1022, 12'd0, 32'h80808080, 32'h01020304, 32'hFF000000,
                  32'h00000000, CHK_GIVEN,
                  {32'h00000000, 32'hFE000000, 32'h00010203, 32'h7F7F7F7F, 24'h0FFBFE});
        // One step further in x or y lands on the bound and is dropped.
        add_block(12'd1023, 12'd5, 12'd0, '1, '1, '1, '1, CHK_DROP, '0);
        add_block(12'd5, 12'd1023, 12'd0, '1, '1, '1, '1, CHK_DROP, '0);
        add_block(12'd4095, 12'd4095, 12'd4095, '1, '1, '1, '1, CHK_DROP, '0);
        // Far below the region top alpha goes negative.
        add_block(12'd10, 12'd0, 12'd4095, '1, '1, '1, '1, CHK_DROP, '0);
        // Mid-range distances, and both sides of the snapping limit.
        add_block(12'd500, 12'd300, 12'd1000, 32'hA1B2C3D4, 32'h5E6F7081, 32'hFFFFFFFF,
                  32'h00FF00FF, CHK_PREDICT, '0);
        add_block(12'd800, 12'd100, 12'd2500, 32'h12345678, 32'h9ABCDEF0, 32'h80808080,
                  32'h7F7F7F7F, CHK_PREDICT, '0);
        add_block(12'd200, 12'd600, 12'd630, 32'hDEADBEEF, 32'hCAFEF00D, 32'h0F0F0F0F,
                  32'hF0F0F0F0, CHK_PREDICT, '0);
        add_block(12'd400, 12'd400, 12'd409, 32'h11223344, 32'h55667788, 32'h99AABBCC,
                  32'hDDEEFF00, CHK_PREDICT, '0);
        add_block(12'd400, 12'd400, 12'd410, 32'h11223344, 32'h55667788, 32'h99AABBCC,
                  32'hDDEEFF00, CHK_PREDICT, '0);
        // Largest frame step: every block is far past its lifetime.
        add_write(CFG_STEP, 15'h7FFF);
        add_block(12'd100, 12'd0, 12'd0, '1, '1, '1, '1, CHK_DROP, '0);
        add_block(12'd100, 12'd4095, 12'd0, '1, '1, '1, '1, CHK_DROP, '0);
        // A zero width makes the x bound negative, so every block is dropped.
        add_write(CFG_STEP, 15'd0);
        add_write(CFG_WIDTH, 15'd0);
        add_block(12'd0, 12'd0, 12'd0, '1, '1, '1, '1, CHK_DROP, '0);
        // Height written with its unused top bits set reads back as 8191, so the
        // index 100 + 4000 * 8191 wraps to its low 24 bits.
        add_write(CFG_WIDTH, 15'd4096);
        add_write(CFG_HEIGHT, 15'h7FFF);
        add_block(12'd4000, 12'd100, 12'd0, 32'h00FF80FF, 32'hFFFFFFFF, 32'h01010101,
                  32'h02020202, CHK_GIVEN,
                  {32'h01010101, 32'h00000000, 32'hFEFEFEFE, 32'h00FE7FFE, 24'hF3F0C4});
        // A write to the spare index must leave the same block unchanged.
        add_write(CFG_SPARE, 15'h7FFF);
        add_block(12'd4000, 12'd100, 12'd0, 32'h00FF80FF, 32'hFFFFFFFF, 32'h01010101,
                  32'h02020202, CHK_GIVEN,
                  {32'h01010101, 32'h00000000, 32'hFEFEFEFE, 32'h00FE7FFE, 24'hF3F0C4});
        // Zero and one as heights leave no room in y.
        add_write(CFG_HEIGHT, 15'd0);
        add_block(12'd0, 12'd0, 12'd0, '1, '1, '1, '1, CHK_DROP, '0);
        add_write(CFG_HEIGHT, 15'd1);
        add_block(12'd0, 12'd0, 12'd0, '1, '1, '1, '1, CHK_DROP, '0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WRITE) begin
                settle();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
                n_settings++;
            end else begin
                send_block(dir_rows[i].blk, dir_rows[i].chk, dir_rows[i].given);
                maybe_pause();
            end
        end

        // Random phases. The first three use extreme registers; the rest draw
        // sizes and frame steps where plenty of blocks survive. The last phase
        // runs with no idling on either side.
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin
                    wv = 15'd1;
                    hv = 15'd1;
                    sv = 15'd0;
                    n_items = 40;
                end
                1: begin
                    wv = 15'd4096;
                    hv = 15'd4096;
                    sv = 15'd0;
                    n_items = 40;
                end
                2: begin
                    wv = 15'h1FFF;
                    hv = 15'h1FFF;
                    sv = 15'd0;
                    n_items = 40;
                end
                default: begin
                    wv = 15'($urandom_range(16, 4096));
                    hv = 15'($urandom_range(16, 4096));
                    sv = 15'($urandom_range(0, 2500));
                    n_items = 150;
                end
            endcase
            settle();
            write_reg(CFG_WIDTH, wv);
            write_reg(CFG_HEIGHT, hv);
            write_reg(CFG_STEP, sv);
            n_settings++;

            if (ph == 9) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = pcts[$urandom_range(0, 2)];
                rx_idle_pct = pcts[$urandom_range(0, 2)];
            end

            for (int i = 0; i < n_items; i++) begin
                // In one phase the receiver holds off while the sender keeps
                // offering back to back; afterwards the sender waits for every
                // owed word before it carries on.
                if (ph == 4 && i == 10) begin
                    hold_req = 1'b1;
                    burst = 1'b1;
                end
                if (ph == 4 && i == 70) begin
                    settle();
                    burst = 1'b0;
                end
                send_block(make_block(), CHK_PREDICT, '0);
                if (!burst) begin
                    maybe_pause();
                end
            end
        end

        // All blocks are in: wait for the owed words, then let the pipeline drain
        // so that any stray word still shows up before the verdict.
        settle();

        $display("Ran %0d blocks over %0d register settings: %0d words checked, %0d dropped.",
                 n_blocks, n_settings, n_words, n_dropped);
        if (n_err == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_CYCLES * 20);
        $display("Run did not finish within %0d cycles.", LIMIT_CYCLES);
        $display("TB_ERROR");
        $finish;
    end

endmodule
